### sv/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define CHK_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/a64pcr_pkg.sv
package a64pcr_pkg;

    localparam int unsigned MaxWords = 7;
    localparam int unsigned QueueDepth = 2;

    localparam logic [31:0] OP_LDR_X17_8   = 32'h5800_0051;
    localparam logic [31:0] OP_BR_X17      = 32'hD61F_0220;
    localparam logic [31:0] OP_BLR_X17     = 32'hD63F_0220;
    localparam logic [31:0] OP_B_20        = 32'h1400_0005;
    localparam logic [31:0] OP_B_12        = 32'h1400_0003;
    localparam logic [31:0] OP_LDR_XD_8    = 32'h5800_0040;
    localparam logic [31:0] OP_LDR_XT_12   = 32'h5800_0060;
    localparam logic [31:0] OP_LDR_XT_XT   = 32'hF940_0000;
    localparam logic [31:0] OP_STP_X16_X17 = 32'hA93F_47F0;
    localparam logic [31:0] OP_LDR_X17_16  = 32'h5800_0091;
    localparam logic [31:0] OP_RESTORE_X17 = 32'hF85F_83F1;
    localparam logic [31:0] OP_LDR_S_X17   = 32'hBD40_0220;
    localparam logic [31:0] OP_LDR_D_X17   = 32'hFD40_0220;
    localparam logic [31:0] OP_LDR_Q_X17   = 32'h3DC0_0220;

    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_ADR,
        CLS_BRANCH,
        CLS_COND,
        CLS_LDR_X,
        CLS_LDR_VEC
    } cls_t;

    // One relocated instruction: the words of its sequence and the index of its last word.
    typedef struct packed {
        logic [MaxWords-1:0][31:0] words;
        logic [2:0]                last_idx;
    } entry_t;

endpackage

### sv/a64pcr_front.sv
module a64pcr_front
    import a64pcr_pkg::*;
(
    input  logic [31:0] instr,
    input  logic [63:0] orig_pc,
    output entry_t      ent
);

    logic [4:0]  rd;
    logic [7:0]  top8;
    logic        is_adr;
    logic        is_b;
    logic        is_bc;
    logic        is_cb;
    logic        is_tb;
    logic        is_ldr;
    cls_t        cls;
    logic [63:0] base;
    logic [63:0] off;
    logic [63:0] target;
    logic [31:0] lit_ld;

    always_comb
    begin
        rd     = instr[4:0];
        top8   = instr[31:24];
        is_adr = (instr[28:24] == 5'b10000);
        is_b   = (instr[30:26] == 5'b00101);
        is_bc  = (top8 == 8'h54) && !instr[4];
        is_cb  = (instr[30:25] == 6'b011010);
        is_tb  = (instr[30:25] == 6'b011011);
        is_ldr = (top8 == 8'h18) || (top8 == 8'h58) || (top8 == 8'h98) ||
                 (top8 == 8'h1C) || (top8 == 8'h5C) || (top8 == 8'h9C);

        if (is_adr)
            cls = CLS_ADR;
        else if (is_b)
            cls = CLS_BRANCH;
        else if (is_bc || is_cb || is_tb)
            cls = CLS_COND;
        else if (is_ldr && (top8 == 8'h58))
            cls = CLS_LDR_X;
        else if (is_ldr)
            cls = CLS_LDR_VEC;
        else
            cls = CLS_OTHER;
    end

    // A single adder serves every class; only the base and the offset are selected.
    always_comb
    begin
        base = orig_pc;
        off  = {{43{instr[23]}}, instr[23:5], 2'b00};
        case (cls)
            CLS_ADR:
            begin
                if (instr[31])
                begin
                    base = {orig_pc[63:12], 12'h000};
                    off  = {{31{instr[23]}}, instr[23:5], instr[30:29], 12'h000};
                end
                else
                begin
                    off = {{43{instr[23]}}, instr[23:5], instr[30:29]};
                end
            end
            CLS_BRANCH:
            begin
                off = {{36{instr[25]}}, instr[25:0], 2'b00};
            end
            CLS_COND:
            begin
                if (is_tb)
                    off = {{48{instr[18]}}, instr[18:5], 2'b00};
            end
            default:
            begin
                off = {{43{instr[23]}}, instr[23:5], 2'b00};
            end
        endcase
        target = base + off;
    end

    always_comb
    begin
        if (top8 == 8'h1C)
            lit_ld = OP_LDR_S_X17 | {27'b0, rd};
        else if (top8 == 8'h5C)
            lit_ld = OP_LDR_D_X17 | {27'b0, rd};
        else
            lit_ld = OP_LDR_Q_X17 | {27'b0, rd};

        ent.words    = '0;
        ent.last_idx = 3'd0;
        case (cls)
            CLS_ADR:
            begin
                ent.words[0] = OP_LDR_XD_8 | {27'b0, rd};
                ent.words[1] = OP_B_12;
                ent.words[2] = target[31:0];
                ent.words[3] = target[63:32];
                ent.last_idx = 3'd3;
            end
            CLS_BRANCH:
            begin
                ent.words[0] = OP_LDR_X17_8;
                ent.words[1] = OP_B_12;
                ent.words[2] = target[31:0];
                ent.words[3] = target[63:32];
                ent.words[4] = instr[31] ? OP_BLR_X17 : OP_BR_X17;
                ent.last_idx = 3'd4;
            end
            CLS_COND:
            begin
                // The test keeps its condition and register, its offset becomes 8 bytes.
                if (is_tb)
                    ent.words[0] = (instr & 32'hFFF8_001F) | 32'h0000_0040;
                else
                    ent.words[0] = (instr & 32'hFF00_001F) | 32'h0000_0040;
                ent.words[1] = OP_B_20;
                ent.words[2] = OP_LDR_X17_8;
                ent.words[3] = OP_BR_X17;
                ent.words[4] = target[31:0];
                ent.words[5] = target[63:32];
                ent.last_idx = 3'd5;
            end
            CLS_LDR_X:
            begin
                ent.words[0] = OP_LDR_XT_12 | {27'b0, rd};
                ent.words[1] = OP_LDR_XT_XT | {22'b0, rd, rd};
                ent.words[2] = OP_B_12;
                ent.words[3] = target[31:0];
                ent.words[4] = target[63:32];
                ent.last_idx = 3'd4;
            end
            CLS_LDR_VEC:
            begin
                ent.words[0] = OP_STP_X16_X17;
                ent.words[1] = OP_LDR_X17_16;
                ent.words[2] = lit_ld;
                ent.words[3] = OP_RESTORE_X17;
                ent.words[4] = OP_B_12;
                ent.words[5] = target[31:0];
                ent.words[6] = target[63:32];
                ent.last_idx = 3'd6;
            end
            default:
            begin
                ent.words[0] = instr;
                ent.last_idx = 3'd0;
            end
        endcase
    end

endmodule

### sv/a64pcr_queue.sv
module a64pcr_queue
    import a64pcr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_ent,
    output logic   can_push,
    input  logic   pop,
    output logic   head_valid,
    output entry_t head_ent
);

    localparam int unsigned PtrW = $clog2(QueueDepth);

    entry_t          mem_reg [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [PtrW:0]   cnt_reg;
    logic [PtrW:0]   cnt_next;
    logic            do_push;
    logic            do_pop;

    assign can_push   = (cnt_reg != (PtrW+1)'(QueueDepth));
    assign head_valid = (cnt_reg != '0);
    assign head_ent   = mem_reg[rd_ptr_reg];
    assign do_push    = push && can_push;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_ent;
    end

endmodule

### sv/a64pcr_back.sv
module a64pcr_back
    import a64pcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  entry_t      head_ent,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] word,
    output logic [2:0]  word_index,
    output logic        last
);

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] word_reg;
    logic [2:0]  index_reg;
    logic        last_reg;
    logic [2:0]  k_reg;
    logic [2:0]  k_next;
    logic        load;
    logic        at_last;

    // The output register reloads whenever it is empty or its word is being taken.
    assign load    = !out_valid_reg || out_ready;
    assign at_last = (k_reg == head_ent.last_idx);
    assign pop     = load && head_valid && at_last;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        k_next         = k_reg;
        if (load)
        begin
            out_valid_next = head_valid;
            if (head_valid)
                k_next = at_last ? 3'd0 : k_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            k_reg         <= 3'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && head_valid)
        begin
            word_reg  <= head_ent.words[k_reg];
            index_reg <= k_reg;
            last_reg  <= at_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign word       = word_reg;
    assign word_index = index_reg;
    assign last       = last_reg;

endmodule

### sv/arm64_pc_relative_relocator_core.sv
// Relocates one ARM64 instruction from its original address into a position-independent
// sequence of one to seven words, one word per output transfer, with last set on the
// final word. The front end classifies the instruction and computes its absolute target
// in the cycle it is accepted, then writes the complete sequence into a two-entry queue;
// the back end plays each queued sequence out through a registered output stage at one
// word per cycle while out_ready is high. An instruction is accepted in any cycle the
// queue has room, so the sustained rate is set by the output channel, which carries one
// word for a passed-through instruction, four for ADR and ADRP, five for B, BL and LDR X
// literal, six for conditional branches and seven for other literal loads. An accepted
// sequence passes through the queue and then the output register before its first word.
module arm64_pc_relative_relocator_core
    import a64pcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] instr,
    input  logic [63:0] orig_pc,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] word,
    output logic [2:0]  word_index,
    output logic        last
);

    entry_t front_ent;
    entry_t head_ent;
    logic   can_push;
    logic   head_valid;
    logic   pop;

    assign in_ready = can_push;

    a64pcr_front u_front (
        .instr   (instr),
        .orig_pc (orig_pc),
        .ent     (front_ent)
    );

    a64pcr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid),
        .push_ent   (front_ent),
        .can_push   (can_push),
        .pop        (pop),
        .head_valid (head_valid),
        .head_ent   (head_ent)
    );

    a64pcr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_ent   (head_ent),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .word       (word),
        .word_index (word_index),
        .last       (last)
    );

endmodule

### sv/a64pcr_checker.sv
`include "assert_macros.svh"

module a64pcr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] word,
    input logic [2:0]  word_index,
    input logic        last
);

    logic [35:0] out_bus;
    logic [2:0]  next_index;
    logic        out_take;

    assign out_bus    = {word, word_index, last};
    assign next_index = word_index + 3'd1;
    assign out_take   = out_valid && out_ready;

    // A stalled word holds its payload.
    `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_bus))

    // The seventh word always closes its sequence.
    `CHK_SAME(a_seven_last, out_valid && (word_index == 3'd6), last)

    // No sequence is two or three words long.
    `CHK_SAME(a_no_short_seq, out_valid && last, (word_index != 3'd1) && (word_index != 3'd2))

    // A word that does not close its sequence is followed, once taken, by the next index.
    `CHK_NEXT(a_index_step, out_take && !last, !out_valid || (word_index == $past(next_index)))

endmodule

bind arm64_pc_relative_relocator_core a64pcr_checker u_a64pcr_checker (.*);

### sim/arm64_pc_relative_relocator_core_tb.sv
module arm64_pc_relative_relocator_core_tb
    import a64pcr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Encoding masks and patterns used to classify an instruction.
    localparam logic [31:0] ADR_MASK   = 32'h9F00_0000;
    localparam logic [31:0] ADR_PAT    = 32'h1000_0000;
    localparam logic [31:0] ADRP_PAT   = 32'h9000_0000;
    localparam logic [31:0] BR_MASK    = 32'h7C00_0000;
    localparam logic [31:0] BR_PAT     = 32'h1400_0000;
    localparam logic [31:0] LINK_BIT   = 32'h8000_0000;
    localparam logic [31:0] BCOND_MASK = 32'hFF00_0010;
    localparam logic [31:0] BCOND_PAT  = 32'h5400_0000;
    localparam logic [31:0] CMPBR_MASK = 32'h7E00_0000;
    localparam logic [31:0] CB_PAT     = 32'h3400_0000;
    localparam logic [31:0] TB_PAT     = 32'h3600_0000;
    localparam logic [31:0] LIT_MASK   = 32'hFF00_0000;
    localparam logic [31:0] LIT_W_PAT  = 32'h1800_0000;
    localparam logic [31:0] LIT_X_PAT  = 32'h5800_0000;
    localparam logic [31:0] LIT_SW_PAT = 32'h9800_0000;
    localparam logic [31:0] LIT_S_PAT  = 32'h1C00_0000;
    localparam logic [31:0] LIT_D_PAT  = 32'h5C00_0000;
    localparam logic [31:0] LIT_Q_PAT  = 32'h9C00_0000;
    localparam logic [31:0] NOP_WORD   = 32'hD503_201F;
    localparam logic [63:0] PC_MAX     = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_REPORTED  = 10;
    localparam int DRAIN_CYCLES  = 10;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } reloc_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] instr = '0;
    logic [63:0] orig_pc = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] word;
    logic [2:0]  word_index;
    logic        last;

    reloc_word_t pending_words[$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    arm64_pc_relative_relocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .instr     (instr),
        .orig_pc   (orig_pc),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .word      (word),
        .word_index(word_index),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic cls_t classify(input logic [31:0] ins);
        logic [31:0] top;
        top = ins & LIT_MASK;
        if ((ins & ADR_MASK) == ADR_PAT || (ins & ADR_MASK) == ADRP_PAT)
            return CLS_ADR;
        if ((ins & BR_MASK) == BR_PAT)
            return CLS_BRANCH;
        if ((ins & BCOND_MASK) == BCOND_PAT || (ins & CMPBR_MASK) == CB_PAT
            || (ins & CMPBR_MASK) == TB_PAT)
            return CLS_COND;
        if (top == LIT_X_PAT)
            return CLS_LDR_X;
        if (top == LIT_W_PAT || top == LIT_SW_PAT || top == LIT_S_PAT
            || top == LIT_D_PAT || top == LIT_Q_PAT)
            return CLS_LDR_VEC;
        return CLS_OTHER;
    endfunction

    // Works out the replacement sequence for one instruction and queues its words.
    function automatic void predict_relocation(input logic [31:0] ins, input logic [63:0] pc);
        logic [31:0] seq [MaxWords];
        logic [63:0] target;
        logic [4:0]  rd;
        logic [18:0] imm19;
        logic [31:0] top;
        int          n;
        reloc_word_t w;
        rd = ins[4:0];
        imm19 = ins[23:5];
        top = ins & LIT_MASK;
        target = pc + {{43{imm19[18]}}, imm19, 2'b00};
        n = 1;
        seq[0] = ins;
        case (classify(ins))
            CLS_ADR:
            begin
                if (ins[31])
                    target = {pc[63:12], 12'h000}
                             + {{31{imm19[18]}}, imm19, ins[30:29], 12'h000};
                else
                    target = pc + {{43{imm19[18]}}, imm19, ins[30:29]};
                seq[0] = OP_LDR_XD_8 | 32'(rd);
                seq[1] = OP_B_12;
                seq[2] = target[31:0];
                seq[3] = target[63:32];
                n = 4;
            end
            CLS_BRANCH:
            begin
                target = pc + {{36{ins[25]}}, ins[25:0], 2'b00};
                seq[0] = OP_LDR_X17_8;
                seq[1] = OP_B_12;
                seq[2] = target[31:0];
                seq[3] = target[63:32];
                seq[4] = ins[31] ? OP_BLR_X17 : OP_BR_X17;
                n = 5;
            end
            CLS_COND:
            begin
                // The test is kept and retargeted to skip over the short jump.
                if ((ins & CMPBR_MASK) == TB_PAT)
                begin
                    target = pc + {{48{ins[18]}}, ins[18:5], 2'b00};
                    seq[0] = (ins & 32'hFFF8_001F) | 32'h40;
                end
                else
                    seq[0] = (ins & 32'hFF00_001F) | 32'h40;
                seq[1] = OP_B_20;
                seq[2] = OP_LDR_X17_8;
                seq[3] = OP_BR_X17;
                seq[4] = target[31:0];
                seq[5] = target[63:32];
                n = 6;
            end
            CLS_LDR_X:
            begin
                seq[0] = OP_LDR_XT_12 | 32'(rd);
                seq[1] = OP_LDR_XT_XT | 32'(rd) | (32'(rd) << 5);
                seq[2] = OP_B_12;
                seq[3] = target[31:0];
                seq[4] = target[63:32];
                n = 5;
            end
            CLS_LDR_VEC:
            begin
                seq[0] = OP_STP_X16_X17;
                seq[1] = OP_LDR_X17_16;
                // W and LDRSW literals also land in the Q-register form.
                if (top == LIT_S_PAT)
                    seq[2] = OP_LDR_S_X17 | 32'(rd);
                else if (top == LIT_D_PAT)
                    seq[2] = OP_LDR_D_X17 | 32'(rd);
                else
                    seq[2] = OP_LDR_Q_X17 | 32'(rd);
                seq[3] = OP_RESTORE_X17;
                seq[4] = OP_B_12;
                seq[5] = target[31:0];
                seq[6] = target[63:32];
                n = 7;
            end
            default:
                n = 1;
        endcase
        for (int k = 0; k < n; k++)
        begin
            w.word = seq[k];
            w.index = k[2:0];
            w.last = (k == n - 1);
            pending_words.push_back(w);
        end
    endfunction

    // Valid is only lowered during an idle cycle, so back-to-back words keep it high.
    task automatic send_instr(input logic [31:0] ins, input logic [63:0] pc);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        instr <= ins;
        orig_pc <= pc;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_relocation(ins, pc);
    endtask

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTED)
                    $display("unexpected word %h index %0d last %0b", word, word_index, last);
                mismatch_count++;
            end
            else
            begin
                reloc_word_t exp_w;
                exp_w = pending_words.pop_front();
                if (word !== exp_w.word || word_index !== exp_w.index || last !== exp_w.last)
                begin
                    if (mismatch_count < MAX_REPORTED)
                        $display("mismatch: expected word %h index %0d last %0b, got %h %0d %0b",
                                 exp_w.word, exp_w.index, exp_w.last, word, word_index, last);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d cycles without a transfer", quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [63:0] random_pc();
        case ($urandom_range(7))
            0: return '0;
            1: return PC_MAX;
            2: return {$urandom, 20'hFFFFF, 12'($urandom)};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly well-formed PC-relative encodings with random fields, plus raw noise.
    function automatic logic [31:0] random_instr();
        logic [31:0] r;
        logic [31:0] lit_tops [5];
        lit_tops = '{LIT_W_PAT, LIT_SW_PAT, LIT_S_PAT, LIT_D_PAT, LIT_Q_PAT};
        r = $urandom;
        case ($urandom_range(8))
            0: return (r & ~ADR_MASK) | (r[31] ? ADRP_PAT : ADR_PAT);
            1: return (r & ~BR_MASK) | BR_PAT;
            2: return (r & ~BCOND_MASK) | BCOND_PAT;
            3: return (r & ~CMPBR_MASK) | CB_PAT;
            4: return (r & ~CMPBR_MASK) | TB_PAT;
            5: return (r & ~LIT_MASK) | LIT_X_PAT;
            6: return (r & ~LIT_MASK) | lit_tops[$urandom_range(4)];
            7: return (r & ~LIT_MASK) | LIT_X_PAT | LINK_BIT;
            default: return r;
        endcase
    endfunction

    task automatic test_pass_through();
        send_instr(32'h0000_0000, random_pc());
        send_instr(32'hFFFF_FFFF, PC_MAX);
        send_instr(NOP_WORD, random_pc());
        // Bit 4 set makes this look like B.cond without being one.
        send_instr(BCOND_PAT | 32'h0000_0010, random_pc());
    endtask

    task automatic test_adr_adrp();
        send_instr(ADR_PAT | 32'h607F_FFE0 | 32'd5, random_pc());
        send_instr(ADR_PAT | 32'h0080_0000 | 32'd31, '0);
        send_instr(ADRP_PAT | 32'h60FF_FFE0 | 32'd3, PC_MAX);
        send_instr(ADRP_PAT | 32'h607F_FFE0 | 32'd31, 64'h7FFF_FFFF_FFFF_F123);
    endtask

    task automatic test_branches();
        send_instr(BR_PAT | 32'h01FF_FFFF, PC_MAX);
        send_instr(BR_PAT | LINK_BIT | 32'h0200_0000, '0);
        send_instr(BR_PAT | LINK_BIT | 32'h03FF_FFFF, random_pc());
    endtask

    task automatic test_cond_branches();
        send_instr(BCOND_PAT | 32'h00FF_FFE0 | 32'h0000_000E, '0);
        send_instr(CB_PAT | LINK_BIT | 32'h007F_FFE0 | 32'd31, PC_MAX);
        send_instr(CB_PAT | 32'h0100_0000 | 32'h0080_0000, random_pc());
        send_instr(TB_PAT | LINK_BIT | 32'h00F8_0000 | 32'h0003_FFE0 | 32'd31, PC_MAX);
        send_instr(TB_PAT | 32'h0100_0000 | 32'h0004_0000, '0);
    endtask

    task automatic test_literal_loads();
        send_instr(LIT_W_PAT | 32'h007F_FFE0, PC_MAX);
        send_instr(LIT_X_PAT | 32'h0080_0000 | 32'd31, '0);
        send_instr(LIT_SW_PAT | 32'h00FF_FFE0 | 32'd7, random_pc());
        send_instr(LIT_S_PAT | 32'h0012_3460 | 32'd31, random_pc());
        send_instr(LIT_D_PAT | 32'h0080_0020, random_pc());
        send_instr(LIT_Q_PAT | 32'h007F_FFE0 | 32'd31, PC_MAX);
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_instr(random_instr(), random_pc());
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pass_through();
        test_adr_adrp();
        test_branches();
        test_cond_branches();
        test_literal_loads();

        test_random_traffic(112, 0, 0);
        test_random_traffic(112, 84, 0);
        test_random_traffic(112, 0, 84);
        test_random_traffic(114, 38, 38);

        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
